### sv/sprite_animation_sequencer_macros.svh
// ----------------------------------------------------------------------------
// sprite animation sequencer assertion macros
// shared concurrent assertion forms for the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIMATION_SEQUENCER_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_MACROS_SVH

// same-cycle implication
`define SAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// types and constants shared by the sprite animation sequencer
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int SLOT_W        = 3;
    localparam int FRAME_W       = 8;
    localparam int MS_W          = 16;
    localparam int ACC_W         = 32;
    localparam int PIX_W         = 16;
    localparam int CFG_W         = 8;
    localparam int BITS_PER_STEP = 3;
    localparam int DIV_STEPS     = 3;
    localparam int COL_W         = BITS_PER_STEP * DIV_STEPS;
    localparam int ROW_W         = COL_W + 1;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;
    localparam int MAX_SLOTS     = 2 ** SLOT_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd16;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_LOAD,
        ACT_SELECT,
        ACT_SET_FRAME
    } t_action;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_FRAMES_ACROSS
    } t_reg_idx;

    typedef struct packed {
        t_action              action;
        logic [MS_W-1:0]      elapsed_ms;
        logic [SLOT_W-1:0]    seq_slot;
        logic [FRAME_W-1:0]   length_frames;
        logic [MS_W-1:0]      period_ms;
        logic                 bounce_mode;
        logic [FRAME_W-1:0]   first_col;
        logic [FRAME_W-1:0]   first_row;
        logic                 restart_req;
        logic [FRAME_W-1:0]   frame_pick;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]     src_x;
        logic [PIX_W-1:0]     src_y;
        logic [FRAME_W-1:0]   frame_now;
        logic [SLOT_W-1:0]    slot_now;
        logic                 wrapped_flag;
        logic                 slot_valid;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0]     frame_width;
        logic [CFG_W-1:0]     frame_height;
        logic [CFG_W-1:0]     frames_across;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic acc;
        logic upd;
        logic div_step;
        logic div_first;
        logic mul;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

### sv/sas_if.sv
// ----------------------------------------------------------------------------
// sas channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface sas_in_if;
    import sas_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sas_out_if;
    import sas_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### sv/sas_ctrl.sv
// ----------------------------------------------------------------------------
// sas_ctrl
// sequencing state machine: capture, accumulate, update, divide, multiply
// ----------------------------------------------------------------------------
`include "sprite_animation_sequencer_macros.svh"

module sas_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  sas_pkg::t_status i_status,
    output sas_pkg::t_cmd  o_cmd
);
    import sas_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_UPD,
        S_DIV,
        S_MUL
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_item_ready = i_rst_n;
                if (i_rst_n && i_item_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MUL: begin
                if (i_status.out_free) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `SAS_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, o_item_ready && i_item_valid, r_state == S_ACC, "accepted item did not start")
    `SAS_ASSERT_NOW(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt < CNT_W'(DIV_STEPS), "divide step count out of range")
    `SAS_ASSERT_NEXT(a_mul_waits, i_clk, i_rst_n, r_state == S_MUL && !i_status.out_free, r_state == S_MUL, "result dropped while output busy")
    `SAS_ASSERT_NEXT(a_mul_done, i_clk, i_rst_n, o_cmd.mul, r_state == S_IDLE, "no return to idle after result")

endmodule

### sv/sas_dp.sv
// ----------------------------------------------------------------------------
// sas_dp
// sequence table, tick/load/select/set datapath, column divider and output
// ----------------------------------------------------------------------------
`include "sprite_animation_sequencer_macros.svh"

module sas_dp #(
    parameter int DEPTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sas_pkg::t_cmd        i_cmd,
    output sas_pkg::t_status     o_status,
    input  sas_pkg::t_cfg        i_cfg,
    input  sas_pkg::t_in_item    i_item,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output sas_pkg::t_out_item   o_res
);
    import sas_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int Y_W   = ROW_W + CFG_W;

    // sequence table
    logic [FRAME_W-1:0] r_len    [DEPTH];
    logic [MS_W-1:0]    r_period [DEPTH];
    logic               r_bounce [DEPTH];
    logic [FRAME_W-1:0] r_col    [DEPTH];
    logic [FRAME_W-1:0] r_row    [DEPTH];
    logic [FRAME_W-1:0] r_frame  [DEPTH];
    logic [ACC_W-1:0]   r_acc    [DEPTH];
    logic               r_fwd    [DEPTH];

    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_cur;
    logic               r_restarted;

    t_in_item           r_item;
    logic [ACC_W-1:0]   r_sum;
    logic [COL_W-1:0]   r_dvd;
    logic [FRAME_W-1:0] r_rem;
    logic [COL_W-1:0]   r_quo;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               cur_valid;
    logic               slot_ok;
    logic               slot_known;
    logic [IDX_W-1:0]   slot_idx;
    logic [ACC_W:0]     sum_wide;
    logic [ACC_W-1:0]   n_sum;
    logic               acc_hit;
    logic [FRAME_W-1:0] adv_frame;
    logic               adv_fwd;
    logic               adv_wrap;
    logic [FRAME_W-1:0] fa_eff;
    logic [COL_W-1:0]   n_dvd;
    logic [FRAME_W-1:0] n_rem;
    logic [COL_W-1:0]   n_quo;
    logic [ROW_W-1:0]   row_sum;
    logic [Y_W-1:0]     y_full;
    logic [PIX_W-1:0]   x_full;

    assign cur_valid  = CNT_W'(r_cur) < r_count;
    assign slot_ok    = {1'b0, r_item.seq_slot} < (SLOT_W + 1)'(DEPTH);
    assign slot_known = slot_ok && ({1'b0, r_item.seq_slot} < (SLOT_W + 1)'(r_count));
    assign slot_idx   = r_item.seq_slot[IDX_W-1:0];

    // saturating accumulator add
    assign sum_wide = {1'b0, r_acc[r_cur]} + (ACC_W + 1)'(r_item.elapsed_ms);
    assign n_sum    = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
    assign acc_hit  = r_sum >= ACC_W'(r_period[r_cur]);

    // one frame step
    always_comb begin
        logic [FRAME_W-1:0] f_up;
        logic [FRAME_W-1:0] f_dn;
        f_up      = r_frame[r_cur] + FRAME_W'(1);
        f_dn      = r_frame[r_cur] - FRAME_W'(1);
        adv_frame = f_up;
        adv_fwd   = r_fwd[r_cur];
        adv_wrap  = 1'b0;
        if (r_bounce[r_cur]) begin
            if (r_fwd[r_cur]) begin
                if (f_up == r_len[r_cur]) begin
                    adv_fwd   = 1'b0;
                    adv_frame = r_frame[r_cur];
                end
            end else begin
                adv_frame = f_dn;
                if (f_dn == '0) begin
                    adv_fwd  = 1'b1;
                    adv_wrap = 1'b1;
                end
            end
        end else if (f_up == r_len[r_cur]) begin
            adv_frame = '0;
            adv_wrap  = 1'b1;
        end
    end

    // restoring divide, several quotient bits per cycle
    assign fa_eff = (i_cfg.frames_across == '0) ? CFG_W'(1) : i_cfg.frames_across;

    always_comb begin
        logic [FRAME_W:0] trial;
        n_dvd = i_cmd.div_first ? (COL_W'(r_col[r_cur]) + COL_W'(r_frame[r_cur])) : r_dvd;
        n_rem = i_cmd.div_first ? '0 : r_rem;
        n_quo = i_cmd.div_first ? '0 : r_quo;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            trial = {n_rem, n_dvd[COL_W-1]};
            n_dvd = {n_dvd[COL_W-2:0], 1'b0};
            if (trial >= {1'b0, fa_eff}) begin
                n_rem = FRAME_W'(trial - {1'b0, fa_eff});
                n_quo = {n_quo[COL_W-2:0], 1'b1};
            end else begin
                n_rem = trial[FRAME_W-1:0];
                n_quo = {n_quo[COL_W-2:0], 1'b0};
            end
        end
    end

    assign row_sum = ROW_W'(r_row[r_cur]) + ROW_W'(r_quo);
    assign y_full  = Y_W'(row_sum) * Y_W'(i_cfg.frame_height);
    assign x_full  = PIX_W'(r_rem) * PIX_W'(i_cfg.frame_width);

    assign o_status.out_free = !r_out_valid || i_res_ready;
    assign o_res_valid       = r_out_valid;
    assign o_res             = r_out;

    // table and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) begin
                r_len[s]    <= '0;
                r_period[s] <= '0;
                r_bounce[s] <= 1'b0;
                r_col[s]    <= '0;
                r_row[s]    <= '0;
                r_frame[s]  <= '0;
                r_acc[s]    <= '0;
                r_fwd[s]    <= 1'b1;
            end
            r_count     <= '0;
            r_cur       <= '0;
            r_restarted <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                case (r_item.action)
                    ACT_TICK: begin
                        if (cur_valid) begin
                            if (acc_hit) begin
                                r_acc[r_cur]   <= r_sum - ACC_W'(r_period[r_cur]);
                                r_frame[r_cur] <= adv_frame;
                                r_fwd[r_cur]   <= adv_fwd;
                                if (adv_wrap) begin
                                    r_restarted <= 1'b1;
                                end
                            end else begin
                                r_acc[r_cur] <= r_sum;
                            end
                        end
                    end
                    ACT_LOAD: begin
                        if (slot_ok) begin
                            r_len[slot_idx]    <= r_item.length_frames;
                            r_period[slot_idx] <= r_item.period_ms;
                            r_bounce[slot_idx] <= r_item.bounce_mode;
                            r_col[slot_idx]    <= r_item.first_col;
                            r_row[slot_idx]    <= r_item.first_row;
                            r_frame[slot_idx]  <= '0;
                            r_acc[slot_idx]    <= '0;
                            r_fwd[slot_idx]    <= 1'b1;
                            if (!slot_known) begin
                                r_count <= CNT_W'(r_item.seq_slot) + CNT_W'(1);
                            end
                        end
                    end
                    ACT_SELECT: begin
                        if (slot_known) begin
                            r_cur <= slot_idx;
                            if (r_item.restart_req) begin
                                r_frame[slot_idx] <= '0;
                                r_acc[slot_idx]   <= '0;
                            end
                        end
                    end
                    ACT_SET_FRAME: begin
                        if (cur_valid && (r_item.frame_pick < r_len[r_cur])) begin
                            r_frame[r_cur] <= r_item.frame_pick;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.mul) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item, working and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.acc) begin
            r_sum <= n_sum;
        end
        if (i_cmd.div_step) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.mul) begin
            r_out.slot_now     <= SLOT_W'(r_cur);
            r_out.wrapped_flag <= r_restarted;
            r_out.slot_valid   <= cur_valid;
            if (cur_valid) begin
                r_out.src_x     <= x_full;
                r_out.src_y     <= (|y_full[Y_W-1:PIX_W]) ? '1 : y_full[PIX_W-1:0];
                r_out.frame_now <= r_frame[r_cur];
            end else begin
                r_out.src_x     <= '0;
                r_out.src_y     <= '0;
                r_out.frame_now <= '0;
            end
        end
    end

    `SAS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "sequence count beyond table")
    `SAS_ASSERT_NOW(a_cur_loaded, i_clk, i_rst_n, r_count != '0, cur_valid, "current slot not loaded")
    `SAS_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, i_cmd.mul, r_rem < fa_eff, "column remainder not reduced")

endmodule

### sv/sprite_animation_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_animation_sequencer
// animation sequence table with tick, load, select and set frame actions,
// reporting the source pixel rectangle origin of the current frame
// ----------------------------------------------------------------------------
// channel   dir  protocol      payload
// i_item    in   valid/ready   t_in_item (action and its operands)
// o_res     out  valid/ready   t_out_item (src_x, src_y, frame, slot, flags)
// apb       in   apb write/rd  frame_width, frame_height, frames_across
//
// one item at a time, taken only while idle: capture, accumulator add, table update,
// column divide by frames_across in 3-bit steps, then a multiply step
// the result is held in an output register until it is taken
// reset clears the table and sets the three registers to 16
// a result not yet taken stalls the next item at its multiply step only
// ----------------------------------------------------------------------------
module sprite_animation_sequencer #(
    parameter int NUM_SEQUENCES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sas_in_if.sink                        i_item,
    sas_out_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sas_pkg::PADDR_W-1:0]   paddr,
    input  logic [sas_pkg::PDATA_W-1:0]   pwdata,
    output logic [sas_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import sas_pkg::*;

    localparam int DEPTH = (NUM_SEQUENCES < MAX_SLOTS) ? NUM_SEQUENCES : MAX_SLOTS;

    t_cfg     r_cfg;
    t_cmd     cmd;
    t_status  status;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= CFG_RESET;
            r_cfg.frame_height  <= CFG_RESET;
            r_cfg.frames_across <= CFG_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAME_WIDTH:   r_cfg.frame_width   <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT:  r_cfg.frame_height  <= pwdata[CFG_W-1:0];
                REG_FRAMES_ACROSS: r_cfg.frames_across <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:   prdata = PDATA_W'(r_cfg.frame_width);
            REG_FRAME_HEIGHT:  prdata = PDATA_W'(r_cfg.frame_height);
            REG_FRAMES_ACROSS: prdata = PDATA_W'(r_cfg.frames_across);
            default:           prdata = '0;
        endcase
    end

    sas_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (i_item.ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    sas_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg       (r_cfg),
        .i_item      (i_item.payload),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res       (o_res.payload)
    );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sprite animation sequencer: directed and random
// actions against a behavioral sheet model, with sender gaps, receiver stalls
// and register writes over the apb port between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import sas_pkg::*;

    localparam int TABLE_DEPTH = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    sas_in_if  item_if ();
    sas_out_if res_if ();

    sprite_animation_sequencer #(
        .NUM_SEQUENCES (TABLE_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // sheet model state
    logic [7:0]   anim_len    [TABLE_DEPTH];
    logic [15:0]  anim_period [TABLE_DEPTH];
    logic         anim_bounce [TABLE_DEPTH];
    logic [7:0]   anim_col    [TABLE_DEPTH];
    logic [7:0]   anim_row    [TABLE_DEPTH];
    logic [7:0]   anim_frame  [TABLE_DEPTH];
    logic [31:0]  anim_acc    [TABLE_DEPTH];
    logic         anim_fwd    [TABLE_DEPTH];
    int unsigned  loaded_count;
    logic [2:0]   active_slot;
    logic         wrap_seen;
    logic [7:0]   cfg_fw;
    logic [7:0]   cfg_fh;
    logic [7:0]   cfg_fa;

    t_out_item    expected_origins [$];
    int           err_count = 0;

    int           burst_left = 0;
    bit           gaps_on = 1'b0;
    bit           rx_stalls = 1'b0;
    int           hold_request = 0;
    int           hold_left = 0;
    int           run_left = 0;
    bit           run_ready = 1'b1;

    function automatic void clear_anim_slot(int unsigned s);
        anim_len[s]    = '0;
        anim_period[s] = '0;
        anim_bounce[s] = 1'b0;
        anim_col[s]    = '0;
        anim_row[s]    = '0;
        anim_frame[s]  = '0;
        anim_acc[s]    = '0;
        anim_fwd[s]    = 1'b1;
    endfunction

    function automatic void reset_sheet_model();
        for (int s = 0; s < TABLE_DEPTH; s++) clear_anim_slot(s);
        loaded_count = 0;
        active_slot  = '0;
        wrap_seen    = 1'b0;
        cfg_fw       = CFG_RESET;
        cfg_fh       = CFG_RESET;
        cfg_fa       = CFG_RESET;
    endfunction

    function automatic void step_animation(int unsigned s);
        logic [7:0] f;
        f = anim_frame[s];
        if (anim_bounce[s]) begin
            if (anim_fwd[s]) begin
                f = f + 8'd1;
                if (f == anim_len[s]) begin
                    anim_fwd[s] = 1'b0;
                    f = f - 8'd1;
                end
            end else begin
                f = f - 8'd1;
                if (f == 8'd0) begin
                    anim_fwd[s] = 1'b1;
                    wrap_seen = 1'b1;
                end
            end
        end else begin
            f = f + 8'd1;
            if (f == anim_len[s]) begin
                f = 8'd0;
                wrap_seen = 1'b1;
            end
        end
        anim_frame[s] = f;
    endfunction

    // applies one action to the model and returns the frame origin it reports
    function automatic t_out_item next_frame_origin(t_in_item it);
        t_out_item   res;
        int unsigned s;
        int unsigned k;
        int unsigned fa;
        int unsigned col;
        int unsigned row;
        int unsigned ypix;
        logic [32:0] sum;
        logic        live;
        live = (active_slot < loaded_count);
        s = active_slot;
        case (it.action)
            ACT_TICK: begin
                if (live) begin
                    sum = {1'b0, anim_acc[s]} + 33'(it.elapsed_ms);
                    anim_acc[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (anim_acc[s] >= 32'(anim_period[s])) begin
                        anim_acc[s] = anim_acc[s] - 32'(anim_period[s]);
                        step_animation(s);
                    end
                end
            end
            ACT_LOAD: begin
                for (k = loaded_count; k < it.seq_slot; k++) clear_anim_slot(k);
                if (it.seq_slot >= loaded_count) loaded_count = it.seq_slot + 1;
                clear_anim_slot(it.seq_slot);
                anim_len[it.seq_slot]    = it.length_frames;
                anim_period[it.seq_slot] = it.period_ms;
                anim_bounce[it.seq_slot] = it.bounce_mode;
                anim_col[it.seq_slot]    = it.first_col;
                anim_row[it.seq_slot]    = it.first_row;
            end
            ACT_SELECT: begin
                if (it.seq_slot < loaded_count) begin
                    active_slot = it.seq_slot;
                    if (it.restart_req) begin
                        anim_frame[it.seq_slot] = '0;
                        anim_acc[it.seq_slot]   = '0;
                    end
                end
            end
            ACT_SET_FRAME: begin
                if (live && it.frame_pick < anim_len[s]) anim_frame[s] = it.frame_pick;
            end
            default: ;
        endcase
        res = '0;
        s = active_slot;
        if (active_slot < loaded_count) begin
            fa = (cfg_fa == 8'd0) ? 1 : int'(cfg_fa);
            col = int'(anim_col[s]) + int'(anim_frame[s]);
            row = int'(anim_row[s]) + col / fa;
            col = col % fa;
            ypix = row * int'(cfg_fh);
            res.src_x      = 16'(col * int'(cfg_fw));
            res.src_y      = (ypix > 65535) ? 16'hFFFF : 16'(ypix);
            res.frame_now  = anim_frame[s];
            res.slot_valid = 1'b1;
        end
        res.slot_now     = active_slot;
        res.wrapped_flag = wrap_seen;
        return res;
    endfunction

    function automatic t_in_item noise_item();
        logic [95:0] raw;
        t_in_item    it;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    function automatic t_in_item tick_item(int unsigned ms);
        t_in_item it;
        it = noise_item();
        it.action = ACT_TICK;
        it.elapsed_ms = 16'(ms);
        return it;
    endfunction

    function automatic t_in_item load_item(int unsigned slot, int unsigned len,
                                           int unsigned period, bit bounce,
                                           int unsigned col, int unsigned row);
        t_in_item it;
        it = noise_item();
        it.action        = ACT_LOAD;
        it.seq_slot      = 3'(slot);
        it.length_frames = 8'(len);
        it.period_ms     = 16'(period);
        it.bounce_mode   = bounce;
        it.first_col     = 8'(col);
        it.first_row     = 8'(row);
        return it;
    endfunction

    function automatic t_in_item select_item(int unsigned slot, bit restart);
        t_in_item it;
        it = noise_item();
        it.action      = ACT_SELECT;
        it.seq_slot    = 3'(slot);
        it.restart_req = restart;
        return it;
    endfunction

    function automatic t_in_item set_frame_item(int unsigned pick);
        t_in_item it;
        it = noise_item();
        it.action     = ACT_SET_FRAME;
        it.frame_pick = 8'(pick);
        return it;
    endfunction

    // mostly sensible animation traffic, the rest raw field values
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        int unsigned span;
        it = noise_item();
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
            it.action = ACT_TICK;
            span = 2 * int'(anim_period[active_slot]) + 1;
            if (span > 65535) span = 65535;
            if ($urandom_range(0, 4) != 0) it.elapsed_ms = 16'($urandom_range(0, span));
        end else if (pick < 60) begin
            it.action = ACT_LOAD;
            if ($urandom_range(0, 3) != 0) it.seq_slot = 3'($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0) it.length_frames = 8'($urandom_range(1, 8));
            if ($urandom_range(0, 4) != 0) it.period_ms = 16'($urandom_range(0, 40));
        end else if (pick < 75) begin
            it.action = ACT_SELECT;
        end else begin
            it.action = ACT_SET_FRAME;
            if (anim_len[active_slot] != 8'd0 && $urandom_range(0, 3) != 0)
                it.frame_pick = 8'($urandom_range(0, int'(anim_len[active_slot]) - 1));
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        do @(posedge i_clk); while (!item_if.ready);
        expected_origins.insert(expected_origins.size(), next_frame_origin(it));
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (expected_origins.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FRAME_WIDTH:   cfg_fw = value;
            REG_FRAME_HEIGHT:  cfg_fh = value;
            REG_FRAMES_ACROSS: cfg_fa = value;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== PDATA_W'(value)) begin
            $display("%0t: reg %s readback expected %0d got %0d",
                     $time, idx.name(), value, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_sheet(input logic [7:0] fw, input logic [7:0] fh,
                             input logic [7:0] fa);
        wait_drained();
        cfg_write(REG_FRAME_WIDTH, fw);
        cfg_write(REG_FRAME_HEIGHT, fh);
        cfg_write(REG_FRAMES_ACROSS, fa);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_origins.size() == 0) begin
                $display("%0t: unexpected item expected none got %h",
                         $time, res_if.payload);
                err_count++;
            end else begin
                want = expected_origins.pop_front();
                check_field("src_x", want.src_x, res_if.payload.src_x);
                check_field("src_y", want.src_y, res_if.payload.src_y);
                check_field("frame_now", want.frame_now, res_if.payload.frame_now);
                check_field("slot_now", want.slot_now, res_if.payload.slot_now);
                check_field("wrapped_flag", want.wrapped_flag, res_if.payload.wrapped_flag);
                check_field("slot_valid", want.slot_valid, res_if.payload.slot_valid);
            end
        end
    end

    // receiver: long hold on request, else always ready or, with stalls on, random ready/stall runs
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (!rx_stalls) begin
            res_if.ready <= 1'b1;
        end else begin
            if (run_left == 0) begin
                run_ready = !run_ready;
                run_left = run_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
            end else begin
                run_left--;
            end
            res_if.ready <= run_ready;
        end
    end

    task automatic test_empty_table();
        send_item(tick_item(65535));
        send_item(set_frame_item(0));
        send_item(select_item(3, 1'b1));
    endtask

    task automatic test_load_select();
        send_item(load_item(2, 4, 10, 1'b0, 14, 3));
        send_item(select_item(1, 1'b0));
        send_item(select_item(2, 1'b1));
        send_item(select_item(5, 1'b0));
    endtask

    task automatic test_loop_playback();
        send_item(tick_item(10));
        send_item(tick_item(5));
        send_item(tick_item(5));
        send_item(tick_item(65535));
        send_item(tick_item(0));
    endtask

    task automatic test_pingpong_playback();
        send_item(load_item(3, 3, 0, 1'b1, 0, 0));
        send_item(select_item(3, 1'b0));
        repeat (5) send_item(tick_item(0));
    endtask

    task automatic test_set_frame();
        send_item(set_frame_item(2));
        send_item(set_frame_item(3));
        send_item(set_frame_item(255));
    endtask

    task automatic test_sheet_extremes();
        set_sheet(8'd255, 8'd255, 8'd0);
        send_item(load_item(7, 255, 1, 1'b0, 255, 255));
        send_item(select_item(7, 1'b1));
        send_item(set_frame_item(254));
        set_sheet(8'd255, 8'd255, 8'd255);
        send_item(tick_item(0));
        send_item(tick_item(1));
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        gaps_on = 1'b0;
        hold_request = 250;
        repeat (40) send_item(random_item());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n, input logic [7:0] fw,
                                       input logic [7:0] fh, input logic [7:0] fa,
                                       input bit gaps, input bit stalls);
        set_sheet(fw, fh, fa);
        gaps_on = gaps;
        rx_stalls = stalls;
        repeat (n) send_item(random_item());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        res_if.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        reset_sheet_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_load_select();
        test_loop_playback();
        test_pingpong_playback();
        test_set_frame();
        test_sheet_extremes();

        test_random_traffic(120, 8'd1, 8'd1, 8'd1, 1'b1, 1'b1);
        test_random_traffic(100, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        test_random_traffic(120, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                            8'($urandom_range(1, 255)), 1'b1, 1'b0);
        test_output_backpressure();
        test_random_traffic(100, 8'd8, 8'd32, 8'd0, 1'b0, 1'b1);
        test_random_traffic(120, 8'd16, 8'd16, 8'd16, 1'b1, 1'b1);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
